// ===== design/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, constants and the tempering function of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned IDX_W         = $clog2(STATE_WORDS);

  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC60000;

  localparam int unsigned INIT_SHIFT = 30;
  localparam int unsigned TEMPER_U   = 11;
  localparam int unsigned TEMPER_S   = 7;
  localparam int unsigned TEMPER_T   = 15;
  localparam int unsigned TEMPER_L   = 18;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic seed_load;
    logic seed_run;
    idx_t count;
  } feed_ctrl_t;

  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> TEMPER_U);
    y = y ^ ((y << TEMPER_S) & TEMPER_B);
    y = y ^ ((y << TEMPER_T) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

endpackage

// ===== design/mtp_cell.sv =====
// ----------------------------------------------------------------------------
// mtp_cell
// One state word of the generator; takes the word on d (its neighbor's, or the feed word at the tail) on each shift.
// ----------------------------------------------------------------------------
module mtp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  mtp_pkg::word_t d,
  output mtp_pkg::word_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== design/mtp_feed.sv =====
// ----------------------------------------------------------------------------
// mtp_feed
// Word entering the tail of the chain: seed, init recurrence or twist.
// ----------------------------------------------------------------------------
module mtp_feed (
  input  mtp_pkg::feed_ctrl_t ctrl,
  input  mtp_pkg::word_t      seed_value,
  input  mtp_pkg::word_t      w_head,
  input  mtp_pkg::word_t      w_next,
  input  mtp_pkg::word_t      w_mid,
  input  mtp_pkg::word_t      w_tail,
  output mtp_pkg::word_t      next_word
);

  mtp_pkg::word_t mix;
  mtp_pkg::word_t init_word;
  mtp_pkg::word_t y;
  mtp_pkg::word_t twist_word;

  assign mix       = w_tail ^ (w_tail >> mtp_pkg::INIT_SHIFT);
  assign init_word = mtp_pkg::WORD_W'(mtp_pkg::INIT_MULT * mix)
                   + mtp_pkg::WORD_W'(ctrl.count);

  assign y          = {w_head[mtp_pkg::WORD_W-1], w_next[mtp_pkg::WORD_W-2:0]};
  assign twist_word = w_mid ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_MATRIX : '0);

  always_comb begin
    if (ctrl.seed_load) begin
      next_word = seed_value;
    end else if (ctrl.seed_run) begin
      next_word = init_word;
    end else begin
      next_word = twist_word;
    end
  end

endmodule

// ===== design/mersenne_twister_prng.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_prng
// MT19937 32-bit generator built as a circular chain of 624 word cells.
// ----------------------------------------------------------------------------
// A draw beat's tempered word appears on random_word with strobe high in the
// next cycle, and draws may follow each other every cycle while busy is low.
// A seed beat gives no result and holds busy high while the rest of the state
// is written, one state word a cycle through the single initialization
// multiplier at the tail of the chain. Results cannot be held off: strobe marks
// each one for exactly one cycle. Out of reset the state is all zeros, so draws
// return zero until the first seed.
module mersenne_twister_prng (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type,
  input  logic [31:0]            seed_value,
  output logic                   strobe,
  output logic [31:0]            random_word
);

  mtp_pkg::word_t      words [mtp_pkg::STATE_WORDS];
  mtp_pkg::word_t      next_word;
  mtp_pkg::feed_ctrl_t ctrl;
  mtp_pkg::idx_t       count;
  logic                accept;
  logic                shift;

  assign accept = start && !busy;
  assign shift  = accept || busy;

  assign ctrl.seed_load = accept && (req_type == mtp_pkg::REQ_SEED);
  assign ctrl.seed_run  = busy;
  assign ctrl.count     = count;

  for (genvar k = 0; k < mtp_pkg::STATE_WORDS; k++) begin : g_cell
    if (k == mtp_pkg::STATE_WORDS - 1) begin : g_tail
      mtp_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (next_word),
        .q     (words[k])
      );
    end else begin : g_body
      mtp_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (words[k+1]),
        .q     (words[k])
      );
    end
  end

  mtp_feed u_feed (
    .ctrl       (ctrl),
    .seed_value (seed_value),
    .w_head     (words[0]),
    .w_next     (words[1]),
    .w_mid      (words[mtp_pkg::MIDDLE_OFFSET]),
    .w_tail     (words[mtp_pkg::STATE_WORDS-1]),
    .next_word  (next_word)
  );

  // seed walk and draw strobe: the seed enters first, then one recurrence word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= accept && (req_type == mtp_pkg::REQ_DRAW);
      if (ctrl.seed_load) begin
        busy  <= 1'b1;
        count <= mtp_pkg::IDX_W'(1);
      end else if (busy) begin
        count <= count + mtp_pkg::IDX_W'(1);
        if (count == mtp_pkg::IDX_W'(mtp_pkg::STATE_WORDS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == mtp_pkg::REQ_DRAW)) begin
      random_word <= mtp_pkg::temper(next_word);
    end
  end

endmodule

// ===== sim/tb_mersenne_twister_prng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mersenne_twister_prng
// Self-checking bench for the MT19937 generator: seed and draw beats are
// sent through the start/busy handshake, a local model of the 624-word state
// predicts every tempered word, and each strobed result is compared in order.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_prng;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_BEATS = 180;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        req_type;
  logic [31:0] seed_value;
  logic        strobe;
  logic [31:0] random_word;

  mersenne_twister_prng u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .seed_value  (seed_value),
    .strobe      (strobe),
    .random_word (random_word)
  );

  // local copy of the generator state
  mtp_pkg::word_t mt_words [mtp_pkg::STATE_WORDS];
  logic [9:0]     mt_pos;
  mtp_pkg::word_t pending_words [$];
  int unsigned    errors;
  int unsigned    idle_pct;
  int unsigned    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mtp_pkg::word_t mt_tempered(input mtp_pkg::word_t w);
    mtp_pkg::word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtp_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtp_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  task automatic mt_clear();
    for (int i = 0; i < mtp_pkg::STATE_WORDS; i++) mt_words[i] = '0;
    mt_pos = 10'(mtp_pkg::STATE_WORDS + 1);
  endtask

  task automatic mt_reseed(input mtp_pkg::word_t seed);
    mtp_pkg::word_t w;
    mt_words[0] = seed;
    for (int i = 1; i < mtp_pkg::STATE_WORDS; i++) begin
      w = mt_words[i-1];
      mt_words[i] = mtp_pkg::INIT_MULT * (w ^ (w >> mtp_pkg::INIT_SHIFT))
                  + mtp_pkg::word_t'(i);
    end
    mt_pos = 10'(mtp_pkg::STATE_WORDS);
  endtask

  task automatic mt_regen();
    mtp_pkg::word_t y;
    int unsigned    nxt;
    int unsigned    mid;
    for (int i = 0; i < mtp_pkg::STATE_WORDS; i++) begin
      nxt = (i + 1) % mtp_pkg::STATE_WORDS;
      mid = (i + mtp_pkg::MIDDLE_OFFSET) % mtp_pkg::STATE_WORDS;
      y = (mt_words[i] & 32'h8000_0000) | (mt_words[nxt] & 32'h7FFF_FFFF);
      mt_words[i] = mt_words[mid] ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_MATRIX : 32'h0);
    end
    mt_pos = '0;
  endtask

  task automatic mt_draw();
    if (mt_pos >= mtp_pkg::STATE_WORDS) mt_regen();
    pending_words.push_back(mt_tempered(mt_words[mt_pos]));
    mt_pos = mt_pos + 10'd1;
  endtask

  // one beat through start/busy, then a random gap
  task automatic send_beat(input logic req, input mtp_pkg::word_t seed);
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= req;
    seed_value <= seed;
    do @(posedge clk); while (busy);
    if (req == mtp_pkg::REQ_SEED) mt_reseed(seed);
    else mt_draw();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic mtp_pkg::word_t pick_seed();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_unseeded_draws();
    repeat (3) send_beat(mtp_pkg::REQ_DRAW, $urandom());
  endtask

  task automatic test_seed_extremes();
    send_beat(mtp_pkg::REQ_SEED, 32'h0000_0000);
    repeat (2) send_beat(mtp_pkg::REQ_DRAW, 32'h0000_0000);
    send_beat(mtp_pkg::REQ_SEED, 32'hFFFF_FFFF);
    repeat (2) send_beat(mtp_pkg::REQ_DRAW, 32'hFFFF_FFFF);
    send_beat(mtp_pkg::REQ_SEED, 32'd5489);
    repeat (3) send_beat(mtp_pkg::REQ_DRAW, $urandom());
  endtask

  task automatic test_back_to_back_seeds();
    send_beat(mtp_pkg::REQ_SEED, 32'h0000_0001);
    send_beat(mtp_pkg::REQ_SEED, 32'h8000_0000);
    repeat (2) send_beat(mtp_pkg::REQ_DRAW, 32'h7FFF_FFFF);
    send_beat(mtp_pkg::REQ_SEED, 32'h5555_AAAA);
    send_beat(mtp_pkg::REQ_SEED, 32'hAAAA_5555);
    repeat (2) send_beat(mtp_pkg::REQ_DRAW, 32'h0000_0000);
  endtask

  // seeded runs of draws; a long run crosses the regeneration point
  task automatic test_random_traffic(input int unsigned pct, input bit long_run);
    int unsigned sent;
    int unsigned run_len;
    bit          first;
    idle_pct = pct;
    sent     = 0;
    first    = 1'b1;
    while (sent < PHASE_BEATS) begin
      if (first || $urandom_range(99) < 85) begin
        send_beat(mtp_pkg::REQ_SEED, pick_seed());
        sent++;
      end
      if (first && long_run) run_len = mtp_pkg::STATE_WORDS + $urandom_range(1, 30);
      else if ($urandom_range(9) == 0) run_len = 0;
      else run_len = $urandom_range(1, 40);
      first = 1'b0;
      repeat (run_len) begin
        send_beat(mtp_pkg::REQ_DRAW, $urandom());
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    mtp_pkg::word_t want;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("random_word: no beat expected, actual %08h", random_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (random_word !== want) begin
          $error("random_word: expected %08h actual %08h", want, random_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = mtp_pkg::REQ_SEED;
    seed_value   = '0;
    errors       = 0;
    idle_pct     = 0;
    quiet_cycles = 0;
    mt_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unseeded_draws();
    test_seed_extremes();
    test_back_to_back_seeds();
    test_random_traffic(0, 1'b1);
    test_random_traffic(81, 1'b0);
    test_random_traffic(0, 1'b0);
    test_random_traffic(32, 1'b0);

    @(negedge clk);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
